// File: sv/ial_pkg.sv
`timescale 1ns / 1ps

package ial_pkg;

    // List geometry.
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Internal widths follow from the geometry.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Port field widths.
    localparam int OP_W     = 3;
    localparam int IDX_IN_W = 6;
    localparam int DOUT_W   = 32;
    localparam int ST_W     = 2;
    localparam int OCNT_W   = 6;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLACE  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_REFUSE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [IDX_IN_W-1:0] index;
        logic [DOUT_W-1:0]   data_in;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DOUT_W-1:0] data_out;
        logic [OCNT_W-1:0] count;
        logic              last;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic trav_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trav_more;
        logic trav_end;
    } t_stat;

endpackage

// File: sv/indexed_array_list_engine_top.sv
// A request is captured into the request register as the controller enters execute;
// the execute state computes the first result word, registered onto o_res with o_valid high.
// A new request is taken only while the controller is idle. A traverse walks the list
// through the single read port of the entry array, visiting one entry a cycle.
// Reset (i_rst_n, synchronous, active low) empties the list and idles the controller.
// The receiver cannot stall: each result word is valid for exactly one cycle.
`timescale 1ns / 1ps

module indexed_array_list_engine_top import ial_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    // The controller sequences each request through an execute cycle and, for a
    // traverse, a walk over the remaining entries. The datapath holds the entries,
    // the count, the walk pointer and the registered result word.
    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;

    ial_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    // Insert and delete move all affected entries at once, in parallel; the result word is
    // registered so a new request can be taken while the previous result is shown.
    ial_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res),
        .o_valid (o_valid)
    );

    assign busy = ctrl_busy;

`ifndef SYNTHESIS
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_more_words_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.last) |-> busy)
        else $error("traverse words still due while idle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("no result word two cycles after a request");
`endif

endmodule

// File: sv/ial_ctrl.sv
`timescale 1ns / 1ps

module ial_ctrl import ial_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_TRAV = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.trav_more ? S_TRAV : S_IDLE;
            end
            S_TRAV: begin
                o_cmd.trav_step = 1'b1;
                if (i_stat.trav_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: sv/ial_dp.sv
`timescale 1ns / 1ps

module ial_dp import ial_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_res  o_res,
    output logic  o_valid
);

    t_req             r_req;
    t_word            r_entries [CAPACITY];
    t_word            n_entries [CAPACITY];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] n_ptr;
    t_res             r_res;
    t_res             n_res;
    logic             r_res_vld;
    logic             n_res_vld;

    logic [IDX_W-1:0]    idx_a;
    logic [IDX_W-1:0]    rd_addr;
    t_word               rd_word;
    logic [IDX_IN_W-1:0] cnt_ext;
    logic                is_full;
    logic                is_empty;
    logic                idx_le;
    logic                idx_lt;
    t_word               wr_val;

    assign idx_a    = r_req.index[IDX_W-1:0];
    assign cnt_ext  = IDX_IN_W'(r_count);
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign idx_le   = (r_req.index <= cnt_ext);
    assign idx_lt   = (r_req.index < cnt_ext);
    assign wr_val   = DATA_WIDTH'(r_req.data_in);

    // Single read port: the request index, entry zero for a traverse, or the walk pointer.
    always_comb begin
        if (i_cmd.exec && (r_req.op == OP_TRAVERSE)) begin
            rd_addr = '0;
        end else if (i_cmd.exec) begin
            rd_addr = idx_a;
        end else begin
            rd_addr = r_ptr[IDX_W-1:0];
        end
    end

    assign rd_word = r_entries[rd_addr];

    assign o_stat.trav_more = (r_req.op == OP_TRAVERSE) && (r_count > CNT_W'(1));
    assign o_stat.trav_end  = (CNT_W'(r_ptr + CNT_W'(1)) == r_count);

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_res     = r_res;
        n_res_vld = 1'b0;
        if (i_cmd.exec) begin
            n_res.status   = ST_OK;
            n_res.data_out = '0;
            n_res.last     = 1'b1;
            n_ptr          = CNT_W'(1);
            unique case (r_req.op)
                OP_INSERT: begin
                    if (is_full) begin
                        n_res.status = ST_REFUSE;
                    end else if (!idx_le) begin
                        n_res.status = ST_RANGE;
                    end else begin
                        // Every entry from the index upward moves up by one in parallel.
                        for (int i = 1; i < CAPACITY; i++) begin
                            if (IDX_IN_W'(i) > r_req.index) begin
                                n_entries[i] = r_entries[i-1];
                            end
                        end
                        n_entries[idx_a] = wr_val;
                        n_count          = CNT_W'(r_count + CNT_W'(1));
                    end
                end
                OP_RETRIEVE: begin
                    if (!idx_lt) begin
                        n_res.status = ST_RANGE;
                    end else begin
                        n_res.data_out = DOUT_W'(rd_word);
                    end
                end
                OP_DELETE: begin
                    if (is_empty) begin
                        n_res.status = ST_REFUSE;
                    end else if (!idx_lt) begin
                        n_res.status = ST_RANGE;
                    end else begin
                        n_res.data_out = DOUT_W'(rd_word);
                        // Entries above the index move down by one in parallel.
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            if (IDX_IN_W'(i) >= r_req.index) begin
                                n_entries[i] = r_entries[i+1];
                            end
                        end
                        n_count = CNT_W'(r_count - CNT_W'(1));
                    end
                end
                OP_REPLACE: begin
                    if (!idx_lt) begin
                        n_res.status = ST_RANGE;
                    end else begin
                        n_entries[idx_a] = wr_val;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                OP_TRAVERSE: begin
                    if (is_empty) begin
                        n_res.status = ST_REFUSE;
                    end else begin
                        n_res.data_out = DOUT_W'(rd_word);
                        n_res.last     = (r_count == CNT_W'(1));
                    end
                end
                default: begin
                    n_res.status = ST_REFUSE;
                end
            endcase
            n_res.count = OCNT_W'(n_count);
            n_res_vld   = 1'b1;
        end else if (i_cmd.trav_step) begin
            n_res.status   = ST_OK;
            n_res.data_out = DOUT_W'(rd_word);
            n_res.count    = OCNT_W'(r_count);
            n_res.last     = o_stat.trav_end;
            n_ptr          = CNT_W'(r_ptr + CNT_W'(1));
            n_res_vld      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        r_entries <= n_entries;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_res_vld <= n_res_vld;
        end
    end

    assign o_res   = r_res;
    assign o_valid = r_res_vld;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_walk_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.trav_step |-> (r_ptr < r_count))
        else $error("traverse pointer beyond the list");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == CNT_W'($past(r_count) + CNT_W'(1))) ||
             (r_count == CNT_W'($past(r_count) - CNT_W'(1))) ||
             (r_count == '0)))
        else $error("entry count moved by more than one");

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("entry count changed outside request execution");
`endif

endmodule
